// ===== rtl/core/srq_pkg.sv =====
// Package for the strict-priority ready queue.
// Holds the field widths, parameter defaults, command codes and shared types.
// Self-contained; every other file of the block but srq_ram imports it.
`timescale 1ns / 1ps

package srq_pkg;

	// Parameter defaults
	localparam int SRQ_LEVELS       = 4;
	localparam int SRQ_LEVEL_DEPTH  = 256;
	localparam int SRQ_TASK_ID_BITS = 10;

	// Fixed widths of the transaction fields
	localparam int ID_FIELD_W    = 10;
	localparam int LEVEL_FIELD_W = 2;
	localparam int PRIO_FIELD_W  = 2;

	// Command codes
	localparam logic CMD_PUSH  = 1'b0;
	localparam logic CMD_FETCH = 1'b1;

	// Controller states
	typedef enum logic [0:0] {
		ST_IDLE,
		ST_READ
	} srq_state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic accept;     // take the input transaction this cycle
		logic load_fetch; // ring read data is back, load the fetch result
	} srq_ctl_t;

	// Datapath to controller status
	typedef struct packed {
		logic fetch_req; // the offered transaction is a fetch
	} srq_sts_t;

endpackage

// ===== rtl/core/strict_priority_ready_queue_top.sv =====
// Strict-priority ready queue, top level: srq_ctrl sequences srq_dpath.
// Push: result registered in the cycle after it is taken; one push per cycle unless
// the output stalls. Fetch: the ring memory read is registered, then ST_READ loads the
// result; no transaction is taken meanwhile. The result register decouples the output.
// Reset clears all ring pointers (every level empty); ring contents stay unset.
`timescale 1ns / 1ps

module strict_priority_ready_queue_top
	import srq_pkg::*;
#(
	parameter int LEVELS       = SRQ_LEVELS,
	parameter int LEVEL_DEPTH  = SRQ_LEVEL_DEPTH,
	parameter int TASK_ID_BITS = SRQ_TASK_ID_BITS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     cmd,
	input  logic [ID_FIELD_W-1:0]    task_id,
	input  logic [PRIO_FIELD_W-1:0]  priority_req,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic                     ok,
	output logic [ID_FIELD_W-1:0]    out_task_id,
	output logic [LEVEL_FIELD_W-1:0] out_level
);

	srq_ctl_t ctl;
	srq_sts_t sts;

	srq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.ctl       (ctl)
	);

	srq_dpath #(
		.LEVELS       (LEVELS),
		.LEVEL_DEPTH  (LEVEL_DEPTH),
		.TASK_ID_BITS (TASK_ID_BITS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.task_id      (task_id),
		.priority_req (priority_req),
		.ctl          (ctl),
		.sts          (sts),
		.ok           (ok),
		.out_task_id  (out_task_id),
		.out_level    (out_level)
	);

endmodule

// ===== rtl/core/srq_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies; contents are undefined until written.
`timescale 1ns / 1ps

module srq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/core/srq_ctrl.sv =====
// Controller of the strict-priority ready queue: handshake and sequencing FSM.
// Depends on srq_pkg; drives srq_dpath through srq_ctl_t commands.
`timescale 1ns / 1ps

module srq_ctrl
	import srq_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	output logic     out_valid,
	input  logic     out_stall,
	input  srq_sts_t sts,
	output srq_ctl_t ctl
);

	srq_state_t state_q;
	srq_state_t state_nxt;
	logic       out_valid_q;
	logic       out_take;

	assign out_take  = out_valid_q && !out_stall;
	assign out_valid = out_valid_q;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state and commands
	always_comb begin
		state_nxt      = state_q;
		in_stall       = 1'b1;
		ctl.accept     = 1'b0;
		ctl.load_fetch = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall   = out_valid_q && out_stall;
				ctl.accept = in_valid && !in_stall;
				if (ctl.accept && sts.fetch_req) begin
					state_nxt = ST_READ;
				end
			end
			ST_READ: begin
				ctl.load_fetch = 1'b1;
				state_nxt      = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// Hold the result valid until the transaction is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((ctl.accept && !sts.fetch_req) || ctl.load_fetch) begin
			out_valid_q <= 1'b1;
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	// The result register is free by the time fetch data returns
	a_read_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |-> !out_valid_q)
		else $error("fetch data returned while result register is occupied");

	// A fetch in ST_READ always produces a result on the following cycle
	a_read_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |=> (out_valid_q && state_q == ST_IDLE))
		else $error("fetch did not produce a result");

	// No transaction is taken while a fetch is in flight
	a_no_accept_in_read: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.accept && sts.fetch_req) |=> (state_q == ST_READ && in_stall))
		else $error("transaction taken during a fetch");

endmodule

// ===== rtl/core/srq_dpath.sv =====
// Datapath of the strict-priority ready queue: per-level ring pointers,
// priority encoder, ring memory and result registers.
// Depends on srq_pkg and srq_ram; sequenced by srq_ctrl.
`timescale 1ns / 1ps

module srq_dpath
	import srq_pkg::*;
#(
	parameter int LEVELS       = SRQ_LEVELS,
	parameter int LEVEL_DEPTH  = SRQ_LEVEL_DEPTH,
	parameter int TASK_ID_BITS = SRQ_TASK_ID_BITS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cmd,
	input  logic [ID_FIELD_W-1:0]    task_id,
	input  logic [PRIO_FIELD_W-1:0]  priority_req,
	input  srq_ctl_t                 ctl,
	output srq_sts_t                 sts,
	output logic                     ok,
	output logic [ID_FIELD_W-1:0]    out_task_id,
	output logic [LEVEL_FIELD_W-1:0] out_level
);

	localparam int PTR_W   = $clog2(LEVEL_DEPTH);
	localparam int LVL_W   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int ADDR_W  = LVL_W + PTR_W;
	localparam int RAM_D   = 1 << ADDR_W;
	localparam int IDW_W   = (TASK_ID_BITS > ID_FIELD_W) ? TASK_ID_BITS : ID_FIELD_W;
	localparam int LVW_W   = (LVL_W > LEVEL_FIELD_W) ? LVL_W : LEVEL_FIELD_W;
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(LEVEL_DEPTH - 1);

	logic [PTR_W-1:0] wr_ptr_q [LEVELS];
	logic [PTR_W-1:0] rd_ptr_q [LEVELS];
	logic [LEVELS-1:0] empty;

	logic [LVL_W-1:0] push_lvl;
	logic             push_lvl_ok;
	logic [PTR_W-1:0] push_nxt;
	logic             push_full;
	logic             push_ok;
	logic             push_go;

	logic [LVL_W-1:0] fetch_lvl;
	logic             fetch_hit;
	logic             fetch_go;

	logic [TASK_ID_BITS-1:0] ram_rdata;
	logic [IDW_W-1:0]        id_wide;
	logic [LVW_W-1:0]        lvl_wide;

	logic             hit_s1;
	logic [LVL_W-1:0] level_s1;
	logic             ok_q;
	logic [ID_FIELD_W-1:0]    task_q;
	logic [LEVEL_FIELD_W-1:0] level_q;

	function automatic logic [PTR_W-1:0] ptr_advance(input logic [PTR_W-1:0] p);
		return (p == PTR_LAST) ? '0 : p + 1'b1;
	endfunction

	assign sts.fetch_req = (cmd == CMD_FETCH);

	// Empty flags per level
	always_comb begin
		for (int l = 0; l < LEVELS; l++) begin
			empty[l] = (rd_ptr_q[l] == wr_ptr_q[l]);
		end
	end

	// Push: check level range and fullness
	assign push_lvl    = LVL_W'(priority_req);
	assign push_lvl_ok = (int'(priority_req) < LEVELS);
	assign push_nxt    = ptr_advance(wr_ptr_q[push_lvl]);
	assign push_full   = (push_nxt == rd_ptr_q[push_lvl]);
	assign push_ok     = push_lvl_ok && !push_full;
	assign push_go     = ctl.accept && !sts.fetch_req && push_ok;

	// Fetch: pick the lowest-numbered level that holds an id
	always_comb begin
		fetch_lvl = '0;
		for (int l = LEVELS - 1; l >= 0; l--) begin
			if (!empty[l]) begin
				fetch_lvl = LVL_W'(l);
			end
		end
	end

	assign fetch_hit = ~&empty;
	assign fetch_go  = ctl.accept && sts.fetch_req;

	// Advance ring pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int l = 0; l < LEVELS; l++) begin
				wr_ptr_q[l] <= '0;
				rd_ptr_q[l] <= '0;
			end
		end else begin
			if (push_go) begin
				wr_ptr_q[push_lvl] <= push_nxt;
			end
			if (fetch_go && fetch_hit) begin
				rd_ptr_q[fetch_lvl] <= ptr_advance(rd_ptr_q[fetch_lvl]);
			end
		end
	end

	// Ring memory, one region per level
	srq_ram #(
		.WIDTH (TASK_ID_BITS),
		.DEPTH (RAM_D)
	) u_ring (
		.clk   (clk),
		.we    (push_go),
		.waddr ({push_lvl, wr_ptr_q[push_lvl]}),
		.wdata (TASK_ID_BITS'(task_id)),
		.re    (fetch_go),
		.raddr ({fetch_lvl, rd_ptr_q[fetch_lvl]}),
		.rdata (ram_rdata)
	);

	// Carry the fetch outcome alongside the memory read
	always_ff @(posedge clk) begin
		if (fetch_go) begin
			hit_s1   <= fetch_hit;
			level_s1 <= fetch_lvl;
		end
	end

	assign id_wide  = IDW_W'(ram_rdata);
	assign lvl_wide = LVW_W'(level_s1);

	// Load the result registers
	always_ff @(posedge clk) begin
		if (ctl.accept && !sts.fetch_req) begin
			ok_q    <= push_ok;
			task_q  <= '0;
			level_q <= '0;
		end else if (ctl.load_fetch) begin
			ok_q    <= hit_s1;
			task_q  <= hit_s1 ? id_wide[ID_FIELD_W-1:0] : '0;
			level_q <= hit_s1 ? lvl_wide[LEVEL_FIELD_W-1:0] : '0;
		end
	end

	assign ok          = ok_q;
	assign out_task_id = task_q;
	assign out_level   = level_q;

	// A successful push leaves its level non-empty
	a_push_fills: assert property (@(posedge clk) disable iff (!arst_n)
		push_go |=> !empty[$past(push_lvl)])
		else $error("level empty after a successful push");

	// A successful fetch never draws from a level with a higher-priority id waiting
	a_strict_order: assert property (@(posedge clk) disable iff (!arst_n)
		(fetch_go && fetch_hit) |-> ((((~empty) << (LEVELS - int'(fetch_lvl))) == '0)
			&& !empty[fetch_lvl]))
		else $error("fetch skipped a higher-priority level");

endmodule

// ===== sim/srq_checker.sv =====
// Scoreboard for the strict-priority ready queue: watches both channels,
// predicts each result from its own copy of the level rings, and compares.
// Depends on srq_pkg for field widths, parameter defaults and command codes.
`timescale 1ns / 1ps

module srq_checker
	import srq_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic                     in_stall,
	input  logic                     cmd,
	input  logic [ID_FIELD_W-1:0]    task_id,
	input  logic [PRIO_FIELD_W-1:0]  priority_req,
	input  logic                     out_valid,
	input  logic                     out_stall,
	input  logic                     ok,
	input  logic [ID_FIELD_W-1:0]    out_task_id,
	input  logic [LEVEL_FIELD_W-1:0] out_level,
	output int                       mismatches,
	output int                       outstanding
);

	localparam int PTR_W       = $clog2(SRQ_LEVEL_DEPTH);
	localparam int MAX_REPORTS = 40;

	typedef struct packed {
		logic                     ok;
		logic [ID_FIELD_W-1:0]    tid;
		logic [LEVEL_FIELD_W-1:0] lvl;
	} reply_t;

	// Own copy of the rings: one circular buffer per level, one slot kept free
	logic [SRQ_TASK_ID_BITS-1:0] slot_mem [SRQ_LEVELS][SRQ_LEVEL_DEPTH];
	logic [PTR_W-1:0]            head [SRQ_LEVELS];
	logic [PTR_W-1:0]            tail [SRQ_LEVELS];

	reply_t replies_due [$];
	int     fail_count = 0;
	int     due_count  = 0;

	assign mismatches  = fail_count;
	assign outstanding = due_count;

	// Print the first few, count all
	task automatic report_mismatch(input string what, input int unsigned want_v,
		input int unsigned got_v);
		if (fail_count < MAX_REPORTS)
			$display("%0t srq_checker: %s expected %0d got %0d", $time, what, want_v, got_v);
		fail_count++;
	endtask

	function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(SRQ_LEVEL_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	// Apply one command to the rings and return the result it must produce
	function automatic reply_t serve_command(input logic c, input logic [ID_FIELD_W-1:0] id,
		input logic [PRIO_FIELD_W-1:0] prio);
		reply_t r;
		int     l;
		r = '0;
		if (c == CMD_PUSH) begin
			// refuse a level out of range or a full level
			if (int'(prio) < SRQ_LEVELS) begin
				if (next_slot(tail[prio]) != head[prio]) begin
					slot_mem[prio][tail[prio]] = SRQ_TASK_ID_BITS'(id);
					tail[prio] = next_slot(tail[prio]);
					r.ok = 1'b1;
				end
			end
		end else begin
			// take the oldest id from the lowest non-empty level
			for (l = 0; l < SRQ_LEVELS && !r.ok; l++) begin
				if (head[l] != tail[l]) begin
					r.ok    = 1'b1;
					r.tid   = ID_FIELD_W'(slot_mem[l][head[l]]);
					r.lvl   = LEVEL_FIELD_W'(l);
					head[l] = next_slot(head[l]);
				end
			end
		end
		return r;
	endfunction

	// Compare finished transactions first, then record newly accepted ones
	always @(posedge clk or negedge arst_n) begin
		reply_t want;
		int     l;
		if (!arst_n) begin
			for (l = 0; l < SRQ_LEVELS; l++) begin
				head[l] = '0;
				tail[l] = '0;
			end
			replies_due.delete();
			due_count <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (replies_due.size() == 0) begin
					report_mismatch("result with nothing pending, ok", 0, ok);
				end else begin
					want = replies_due.pop_front();
					if (ok !== want.ok)
						report_mismatch("ok", want.ok, ok);
					if (out_task_id !== want.tid)
						report_mismatch("out_task_id", want.tid, out_task_id);
					if (out_level !== want.lvl)
						report_mismatch("out_level", want.lvl, out_level);
				end
			end
			if (in_valid && !in_stall)
				replies_due.push_back(serve_command(cmd, task_id, priority_req));
			due_count <= replies_due.size();
		end
	end

endmodule

// ===== sim/tb_top.sv =====
// Testbench top for the strict-priority ready queue: clock, reset, stimulus, verdict.
// Depends on srq_pkg, strict_priority_ready_queue_top and srq_checker.
`timescale 1ns / 1ps

module tb_top;
	import srq_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_stall;
	logic                     cmd;
	logic [ID_FIELD_W-1:0]    task_id;
	logic [PRIO_FIELD_W-1:0]  priority_req;
	logic                     out_valid;
	logic                     out_stall;
	logic                     ok;
	logic [ID_FIELD_W-1:0]    out_task_id;
	logic [LEVEL_FIELD_W-1:0] out_level;
	int                       mismatches;
	int                       outstanding;

	int          idle_pct;
	int          stall_pct;
	int unsigned cycle_count = 0;

	strict_priority_ready_queue_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.cmd          (cmd),
		.task_id      (task_id),
		.priority_req (priority_req),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.ok           (ok),
		.out_task_id  (out_task_id),
		.out_level    (out_level)
	);

	srq_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.cmd          (cmd),
		.task_id      (task_id),
		.priority_req (priority_req),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.ok           (ok),
		.out_task_id  (out_task_id),
		.out_level    (out_level),
		.mismatches   (mismatches),
		.outstanding  (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Stall the result channel at random
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// Bound the run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb_top: done, errors");
			$finish;
		end
	end

	task automatic set_idling(input int sender_pct, input int receiver_pct);
		idle_pct = sender_pct;
		stall_pct <= receiver_pct;
	endtask

	// Offer one transaction after a random gap and hold it until taken
	task automatic drive_item(input logic c, input logic [ID_FIELD_W-1:0] id,
		input logic [PRIO_FIELD_W-1:0] prio);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		cmd          <= c;
		task_id      <= id;
		priority_req <= prio;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// Hold the sender off until every pending result has come back
	task automatic wait_drained();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (outstanding != 0);
	endtask

	// Mostly random ids, with the extremes now and then
	function automatic logic [ID_FIELD_W-1:0] pick_id();
		case ($urandom_range(9))
			0:       return '0;
			1:       return '1;
			default: return ID_FIELD_W'($urandom);
		endcase
	endfunction

	task automatic send_mixed(input int count, input int push_pct);
		int n;
		for (n = 0; n < count; n++) begin
			if ($urandom_range(99) < push_pct)
				drive_item(CMD_PUSH, pick_id(), PRIO_FIELD_W'($urandom));
			else
				drive_item(CMD_FETCH, ID_FIELD_W'($urandom), PRIO_FIELD_W'($urandom));
		end
	endtask

	// Push hard at one level so it fills and then refuses
	task automatic send_fill(input int lvl, input int count);
		int n;
		for (n = 0; n < count; n++) begin
			drive_item(CMD_PUSH, pick_id(), PRIO_FIELD_W'(lvl));
		end
	endtask

	initial begin
		arst_n       <= 1'b0;
		in_valid     <= 1'b0;
		cmd          <= CMD_PUSH;
		task_id      <= '0;
		priority_req <= '0;
		set_idling(0, 0);
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fetch with every level empty, junk in the unused fields
		drive_item(CMD_FETCH, '1, '1);
		// an id at every level, the extremes at levels 0 and 3, out of order
		drive_item(CMD_PUSH, '1, 2'd3);
		drive_item(CMD_PUSH, '0, 2'd0);
		drive_item(CMD_PUSH, 10'h155, 2'd2);
		drive_item(CMD_PUSH, 10'h2AA, 2'd1);
		drive_item(CMD_PUSH, '1, 2'd0);
		drive_item(CMD_PUSH, '0, 2'd3);
		// drain in priority order, oldest first within a level, then empty again
		repeat (7) drive_item(CMD_FETCH, '0, '0);
		// a higher level overtakes ids already waiting lower down
		drive_item(CMD_PUSH, 10'h0F0, 2'd2);
		drive_item(CMD_PUSH, 10'h30F, 2'd2);
		drive_item(CMD_FETCH, '0, 2'd1);
		drive_item(CMD_PUSH, 10'h001, 2'd0);
		drive_item(CMD_FETCH, '1, 2'd2);
		drive_item(CMD_FETCH, '0, 2'd3);
		drive_item(CMD_FETCH, '1, '0);
		wait_drained();

		// back to back, balanced push and fetch
		set_idling(0, 0);
		send_mixed(350, 50);
		// fill one level past full with a slow sender, then drain a little
		set_idling(60, 0);
		send_fill($urandom_range(3), 262);
		send_mixed(100, 30);
		wait_drained();
		// fetch-heavy under receiver stalls
		set_idling(0, 60);
		send_mixed(350, 35);
		// both sides idling, fill again and drain
		set_idling(36, 36);
		send_fill($urandom_range(3), 262);
		send_mixed(100, 20);

		wait_drained();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/srq_pkg.sv
rtl/core/srq_ram.sv
rtl/core/srq_ctrl.sv
rtl/core/srq_dpath.sv
rtl/core/strict_priority_ready_queue_top.sv
sim/srq_checker.sv
sim/tb_top.sv
